[sv/dorq_pkg.sv]
// Shared types and codes for the deadline ordered ready queue.
package dorq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FAIL = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_READ,
      S_EVAL,
      S_SHIFT_READ,
      S_SHIFT_WRITE,
      S_INS_HEAD,
      S_HEAD_READ,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      status_type  status;
      logic        head_valid;
      logic [7:0]  head_task;
      logic [31:0] head_deadline;
      logic [4:0]  occupancy;
   } rsp_word_type;

endpackage

[sv/dorq_if.sv]
// Request and response channel interfaces for the deadline ordered ready queue.
interface dorq_req_if;
   import dorq_pkg::*;

   logic        valid;
   logic        ready;
   op_type      mode;
   logic [7:0]  task_id;
   logic [31:0] deadline;

   modport source (output valid, output mode, output task_id, output deadline, input ready);
   modport sink   (input valid, input mode, input task_id, input deadline, output ready);
endinterface

interface dorq_rsp_if;
   import dorq_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   logic        head_valid;
   logic [7:0]  head_task;
   logic [31:0] head_deadline;
   logic [4:0]  occupancy;

   modport source (output valid, output status, output head_valid, output head_task,
                   output head_deadline, output occupancy, input ready);
   modport sink   (input valid, input status, input head_valid, input head_task,
                   input head_deadline, input occupancy, output ready);
endinterface

[sv/dorq_store.sv]
// Entry memory: one write port, one registered read port.
module dorq_store #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int DEADLINE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
   output logic [7:0]                       rd_id,
   output logic [DEADLINE_BITS-1:0]         rd_dl,
   input  logic                             wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
   input  logic [7:0]                       wr_id,
   input  logic [DEADLINE_BITS-1:0]         wr_dl
);
   logic [7:0]               mem_id_ff [QUEUE_DEPTH];
   logic [DEADLINE_BITS-1:0] mem_dl_ff [QUEUE_DEPTH];
   logic [7:0]               rd_id_ff;
   logic [DEADLINE_BITS-1:0] rd_dl_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_id_ff[wr_addr] <= wr_id;
         mem_dl_ff[wr_addr] <= wr_dl;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id_ff <= mem_id_ff[rd_addr];
         rd_dl_ff <= mem_dl_ff[rd_addr];
      end
   end

   assign rd_id = rd_id_ff;
   assign rd_dl = rd_dl_ff;
endmodule

[sv/dorq_seq.sv]
// Sequencer: walks the sorted entries one at a time through the single read port of the store.
module dorq_seq #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int DEADLINE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  dorq_pkg::op_type                 in_mode,
   input  logic [7:0]                       in_id,
   input  logic [DEADLINE_BITS-1:0]         in_dl,
   output logic                             res_valid,
   input  logic                             res_ready,
   output dorq_pkg::rsp_word_type           res_word,
   output logic                             rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
   input  logic [7:0]                       rd_id,
   input  logic [DEADLINE_BITS-1:0]         rd_dl,
   output logic                             wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
   output logic [7:0]                       wr_id,
   output logic [DEADLINE_BITS-1:0]         wr_dl
);
   import dorq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

   seq_state_type            state_ff, state_in;
   op_type                   mode_ff, mode_in;
   logic [7:0]               id_ff, id_in;
   logic [DEADLINE_BITS-1:0] dl_ff, dl_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   status_type               status_ff, status_in;
   logic [CNT_W-1:0]         idx_nxt;
   logic                     less;

   assign idx_nxt = idx_ff + ONE;
   assign less    = dl_ff < rd_dl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         idx_ff    <= '0;
         status_ff <= ST_FAIL;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      id_ff   <= id_in;
      dl_ff   <= dl_in;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      id_in     = id_ff;
      dl_in     = dl_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      in_ready  = 1'b0;
      res_valid = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[IDX_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_id     = id_ff;
      wr_dl     = dl_ff;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               mode_in  = in_mode;
               id_in    = in_id;
               dl_in    = in_dl;
               state_in = S_START;
            end
         end
         S_START: begin
            case (mode_ff)
               OP_INSERT: begin
                  if (fill_ff == FULL_CNT) begin
                     status_in = ST_FULL;
                     state_in  = S_HEAD_READ;
                  end else if (fill_ff == '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     fill_in   = ONE;
                     status_in = ST_OK;
                     state_in  = S_HEAD_READ;
                  end else begin
                     idx_in   = fill_ff - ONE;
                     state_in = S_READ;
                  end
               end
               OP_REMOVE, OP_FIND: begin
                  idx_in = '0;
                  if (fill_ff == '0) begin
                     status_in = ST_FAIL;
                     state_in  = S_HEAD_READ;
                  end else begin
                     state_in = S_READ;
                  end
               end
               OP_POP: begin
                  idx_in = '0;
                  if (fill_ff == '0) begin
                     status_in = ST_FAIL;
                     state_in  = S_HEAD_READ;
                  end else begin
                     status_in = ST_OK;
                     if (fill_ff > ONE) begin
                        state_in = S_SHIFT_READ;
                     end else begin
                        fill_in  = '0;
                        state_in = S_HEAD_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_HEAD_READ;
               end
            endcase
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (mode_ff == OP_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = idx_nxt[IDX_W-1:0];
               if (less) begin
                  wr_id = rd_id;
                  wr_dl = rd_dl;
                  if (idx_ff == '0) begin
                     state_in = S_INS_HEAD;
                  end else begin
                     idx_in   = idx_ff - ONE;
                     state_in = S_READ;
                  end
               end else begin
                  fill_in   = fill_ff + ONE;
                  status_in = ST_OK;
                  state_in  = S_HEAD_READ;
               end
            end else if (rd_id == id_ff) begin
               status_in = ST_OK;
               if (mode_ff == OP_FIND) begin
                  state_in = S_HEAD_READ;
               end else if (idx_nxt < fill_ff) begin
                  state_in = S_SHIFT_READ;
               end else begin
                  fill_in  = fill_ff - ONE;
                  state_in = S_HEAD_READ;
               end
            end else if (idx_nxt < fill_ff) begin
               idx_in   = idx_nxt;
               state_in = S_READ;
            end else begin
               status_in = ST_FAIL;
               state_in  = S_HEAD_READ;
            end
         end
         S_SHIFT_READ: begin
            rd_en    = 1'b1;
            rd_addr  = idx_nxt[IDX_W-1:0];
            state_in = S_SHIFT_WRITE;
         end
         S_SHIFT_WRITE: begin
            wr_en  = 1'b1;
            wr_id  = rd_id;
            wr_dl  = rd_dl;
            idx_in = idx_nxt;
            if (idx_nxt < fill_ff - ONE) begin
               state_in = S_SHIFT_READ;
            end else begin
               fill_in  = fill_ff - ONE;
               state_in = S_HEAD_READ;
            end
         end
         S_INS_HEAD: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            fill_in   = fill_ff + ONE;
            status_in = ST_OK;
            state_in  = S_HEAD_READ;
         end
         S_HEAD_READ: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res_word.status     = status_ff;
      res_word.head_valid = fill_ff != '0;
      res_word.occupancy  = 5'(fill_ff);
      if (fill_ff != '0) begin
         res_word.head_task     = rd_id;
         res_word.head_deadline = 32'(rd_dl);
      end else begin
         res_word.head_task     = '0;
         res_word.head_deadline = '0;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= FULL_CNT)
      else $error("fill count above depth");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != S_IDLE && state_ff != S_DONE && state_ff != S_HEAD_READ))
      else $error("write outside a walk");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == ST_FULL) |-> fill_ff == FULL_CNT)
      else $error("full status on a queue with room");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == S_START)
      else $error("accepted word not started");
endmodule

[sv/deadline_ordered_ready_queue_core.sv]
// Top level of the deadline ordered ready queue with its response register.
// Each request runs the start, head read and done states of the sequencer and then the
// response register, plus a read step and an evaluate or write step per entry visited or moved.
// Flow: one request at a time; the walk is bound by the single read port of the entry
// memory and visits one entry at a time.
// Reset: synchronous; clears the sequencer, fill count and response valid, not the memory.
module deadline_ordered_ready_queue_core #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int DEADLINE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   dorq_req_if.sink  req_port,
   dorq_rsp_if.source rsp_port
);
   import dorq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic                     res_valid;
   logic                     res_ready;
   rsp_word_type             res_word;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [7:0]               rd_id;
   logic [DEADLINE_BITS-1:0] rd_dl;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [7:0]               wr_id;
   logic [DEADLINE_BITS-1:0] wr_dl;
   logic                     rsp_valid_ff;
   rsp_word_type             rsp_word_ff;

   dorq_seq #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .DEADLINE_BITS (DEADLINE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_mode   (req_port.mode),
      .in_id     (req_port.task_id),
      .in_dl     (DEADLINE_BITS'(req_port.deadline)),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_word  (res_word),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_id     (rd_id),
      .rd_dl     (rd_dl),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_id     (wr_id),
      .wr_dl     (wr_dl)
   );

   dorq_store #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .DEADLINE_BITS (DEADLINE_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_id   (rd_id),
      .rd_dl   (rd_dl),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_id   (wr_id),
      .wr_dl   (wr_dl)
   );

   assign res_ready = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_word_ff <= res_word;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_word_ff.status;
   assign rsp_port.head_valid    = rsp_word_ff.head_valid;
   assign rsp_port.head_task     = rsp_word_ff.head_task;
   assign rsp_port.head_deadline = rsp_word_ff.head_deadline;
   assign rsp_port.occupancy     = rsp_word_ff.occupancy;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.ready) |=> rsp_port.valid)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.occupancy != 5'd0) |-> rsp_port.head_valid)
      else $error("head valid disagrees with occupancy");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.head_valid) |-> (rsp_port.head_task == 8'd0))
      else $error("head task set on an empty queue");
endmodule

[verif/deadline_ordered_ready_queue_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the deadline ordered ready queue core.
module deadline_ordered_ready_queue_core_test;
   import dorq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 16;
   localparam int LONG_HOLD    = 400;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [7:0]  id;
      logic [31:0] deadline;
   } job_entry_type;

   logic clock;
   logic reset;

   dorq_req_if req_bus ();
   dorq_rsp_if rsp_bus ();

   deadline_ordered_ready_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .DEADLINE_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   job_entry_type held_jobs[$];
   rsp_word_type  pending_responses[$];
   int            error_count   = 0;
   int            burst_left    = 0;
   bit            gaps_enabled  = 1'b1;
   int            stall_request = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_word_type apply_request(op_type op, logic [7:0] id,
                                                  logic [31:0] dl);
      rsp_word_type  word;
      job_entry_type entry;
      int            slot;
      int            i;
      word = '0;
      word.status = ST_FAIL;
      slot = -1;
      case (op)
         OP_INSERT: begin
            if (held_jobs.size() >= QUEUE_DEPTH) begin
               word.status = ST_FULL;
            end else begin
               slot = held_jobs.size();
               for (i = 0; i < held_jobs.size(); i++) begin
                  if (dl < held_jobs[i].deadline) begin
                     slot = i;
                     break;
                  end
               end
               entry.id = id;
               entry.deadline = dl;
               held_jobs.insert(slot, entry);
               word.status = ST_OK;
            end
         end
         OP_REMOVE, OP_FIND: begin
            for (i = 0; i < held_jobs.size(); i++) begin
               if (held_jobs[i].id == id) begin
                  slot = i;
                  break;
               end
            end
            if (slot >= 0) begin
               word.status = ST_OK;
               if (op == OP_REMOVE) held_jobs.delete(slot);
            end
         end
         default: begin
            if (held_jobs.size() > 0) begin
               held_jobs.delete(0);
               word.status = ST_OK;
            end
         end
      endcase
      if (held_jobs.size() > 0) begin
         word.head_valid = 1'b1;
         word.head_task = held_jobs[0].id;
         word.head_deadline = held_jobs[0].deadline;
      end
      word.occupancy = 5'(held_jobs.size());
      return word;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on %s: expected %0h actual %0h", what, want, got);
   endfunction

   function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) note_mismatch(what, want, got);
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            note_mismatch("unexpected response occupancy", 0, rsp_bus.occupancy);
         end else begin
            want = pending_responses.pop_front();
            compare_field("status", want.status, rsp_bus.status);
            compare_field("head_valid", want.head_valid, rsp_bus.head_valid);
            compare_field("head_task", want.head_task, rsp_bus.head_task);
            compare_field("head_deadline", want.head_deadline, rsp_bus.head_deadline);
            compare_field("occupancy", want.occupancy, rsp_bus.occupancy);
         end
      end
   end

   // receiver: long hold on request, otherwise a stall pattern that changes periodically
   initial begin
      int          hold_left;
      int          stall_mode;
      int          phase;
      logic [15:0] pattern;
      hold_left = 0;
      stall_mode = 0;
      phase = 0;
      pattern = '0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            hold_left = stall_request;
            stall_request = 0;
         end
         if (phase == 0) begin
            stall_mode = $urandom_range(0, 2);
            pattern = $urandom;
            phase = 64;
         end
         phase--;
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            case (stall_mode)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = $urandom_range(0, 1);
               default: rsp_bus.ready = pattern[phase % 16];
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("deadline_ordered_ready_queue_core regression: fail");
            $finish;
         end
      end
   end

   // call at a falling edge; returns at a falling edge
   task automatic send_request(op_type op, logic [7:0] id, logic [31:0] dl);
      if (gaps_enabled && burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid = 1'b1;
      req_bus.mode = op;
      req_bus.task_id = id;
      req_bus.deadline = dl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_responses.push_back(apply_request(op, id, dl));
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_random(int insert_weight, int remove_weight, int find_weight,
                              int pop_weight);
      int          pick;
      op_type      op;
      logic [7:0]  id;
      logic [31:0] dl;
      pick = $urandom_range(0, insert_weight + remove_weight + find_weight + pop_weight - 1);
      if (pick < insert_weight) op = OP_INSERT;
      else if (pick < insert_weight + remove_weight) op = OP_REMOVE;
      else if (pick < insert_weight + remove_weight + find_weight) op = OP_FIND;
      else op = OP_POP;
      id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 4) dl = $urandom_range(0, 31);
      else if (pick == 4) dl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      else dl = $urandom;
      send_request(op, id, dl);
   endtask

   task automatic test_empty_queue();
      send_request(OP_POP, 8'd0, 32'd0);
      send_request(OP_REMOVE, 8'd0, 32'd0);
      send_request(OP_FIND, 8'hFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_deadline_order();
      send_request(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 8'hFF, 32'd0);
      send_request(OP_INSERT, 8'd7, 32'd0);
      send_request(OP_INSERT, 8'd7, 32'd5000);
      send_request(OP_FIND, 8'd7, 32'd0);
      send_request(OP_FIND, 8'd42, 32'd0);
      send_request(OP_REMOVE, 8'd7, 32'd0);
      send_request(OP_REMOVE, 8'd42, 32'd0);
      send_request(OP_POP, 8'd0, 32'd0);
   endtask

   task automatic test_full_queue();
      while (held_jobs.size() < QUEUE_DEPTH)
         send_request(OP_INSERT, 8'($urandom_range(0, 255)), $urandom);
      send_request(OP_INSERT, 8'hA5, 32'h5A5A_5A5A);
   endtask

   task automatic test_output_backpressure();
      gaps_enabled = 1'b0;
      @(posedge clock);
      stall_request = LONG_HOLD;
      @(negedge clock);
      repeat (40) send_random(3, 2, 2, 2);
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_fill_heavy();
      repeat (200) send_random(6, 1, 2, 1);
   endtask

   task automatic test_random_drain_heavy();
      repeat (150) send_random(2, 3, 2, 3);
   endtask

   task automatic test_random_back_to_back();
      gaps_enabled = 1'b0;
      repeat (150) send_random(3, 2, 2, 2);
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_mixed();
      repeat (200) send_random(3, 2, 2, 2);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = OP_INSERT;
      req_bus.task_id = '0;
      req_bus.deadline = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_deadline_order();
      test_full_queue();
      test_random_fill_heavy();
      test_output_backpressure();
      test_random_drain_heavy();
      test_random_back_to_back();
      test_random_mixed();

      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("deadline_ordered_ready_queue_core regression: pass");
      end else begin
         $display("deadline_ordered_ready_queue_core regression: fail");
      end
      $finish;
   end

endmodule
